>>> hw/rtl/apcc_pkg.sv
// Shared types and constants for the anchor pair consistency check.
`default_nettype none
package apcc_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned PosW       = 24;
  localparam int unsigned EvalW      = 63;
  localparam int unsigned ShiftW     = 16;
  localparam int unsigned DiffW      = PosW + 3;

  localparam logic [1:0] ReqClear  = 2'd0;
  localparam logic [1:0] ReqAppend = 2'd1;
  localparam logic [1:0] ReqQuery  = 2'd2;

  localparam logic CfgEvalThreshold = 1'b0;
  localparam logic CfgMaxShift      = 1'b1;

  localparam logic [EvalW-1:0]  EvalThresholdReset = 63'h3FF0000000000000;
  localparam logic [ShiftW-1:0] MaxShiftReset      = 16'd50;

  typedef struct packed {
    logic [PosW-1:0]  s1;
    logic [PosW-1:0]  e1;
    logic [PosW-1:0]  s2;
    logic [PosW-1:0]  e2;
    logic [EvalW-1:0] ev;
    logic             valid;
  } anchor_rec_t;

  typedef enum logic [1:0] {
    VerdictSkip,
    VerdictAccept,
    VerdictReject
  } verdict_t;
endpackage
`default_nettype wire

>>> hw/rtl/apcc_cell.sv
// One record cell of the rotating record chain.
`default_nettype none
module apcc_cell (
  input  wire                  clk,
  input  wire                  load_en,
  input  wire                  shift_en,
  input  apcc_pkg::anchor_rec_t load_rec,
  input  apcc_pkg::anchor_rec_t neighbor_rec,
  output apcc_pkg::anchor_rec_t rec
);
  import apcc_pkg::*;

  always_ff @(posedge clk) begin
    if (load_en) begin
      rec <= load_rec;
    end else if (shift_en) begin
      rec <= neighbor_rec;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/apcc_eval.sv
// Checks one stored record against the query interval pair.
`default_nettype none
module apcc_eval (
  input  apcc_pkg::anchor_rec_t       rec,
  input  wire [apcc_pkg::PosW-1:0]    s1,
  input  wire [apcc_pkg::PosW-1:0]    e1,
  input  wire [apcc_pkg::PosW-1:0]    s2,
  input  wire [apcc_pkg::PosW-1:0]    e2,
  input  wire [apcc_pkg::EvalW-1:0]   eval_threshold,
  input  wire [apcc_pkg::ShiftW-1:0]  max_shift,
  output apcc_pkg::verdict_t          verdict
);
  import apcc_pkg::*;

  logic [PosW-1:0] os1, os2, oe1, oe2;
  logic signed [DiffW-1:0] dstart, dstop, astart, astop, lim;

  always_comb begin
    os1 = (s1 > rec.s1) ? s1 : rec.s1;
    os2 = (s2 > rec.s2) ? s2 : rec.s2;
    oe1 = (e1 < rec.e1) ? e1 : rec.e1;
    oe2 = (e2 < rec.e2) ? e2 : rec.e2;
    dstart = $signed({3'b000, os1}) - $signed({3'b000, os2})
           - ($signed({3'b000, rec.s1}) - $signed({3'b000, rec.s2}));
    dstop  = $signed({3'b000, oe1}) - $signed({3'b000, oe2})
           - ($signed({3'b000, rec.e1}) - $signed({3'b000, rec.e2}));
    astart = dstart[DiffW-1] ? -dstart : dstart;
    astop  = dstop[DiffW-1] ? -dstop : dstop;
    lim    = $signed({{(DiffW-ShiftW){1'b0}}, max_shift});

    if (!rec.valid || rec.ev > eval_threshold) begin
      verdict = VerdictSkip;
    end else if (e1 < rec.s1 && e2 < rec.s2) begin
      verdict = VerdictAccept;
    end else if (s1 > rec.e1 && s2 > rec.e2) begin
      verdict = VerdictSkip;
    end else if ((e2 > rec.e2 && e1 < rec.s1) || (e1 > rec.e1 && e2 < rec.s2) ||
                 (s1 < rec.s1 && s2 > rec.e2) || (s2 < rec.s2 && s1 > rec.e1)) begin
      verdict = VerdictReject;
    end else if (astart > lim || astop > lim) begin
      verdict = VerdictReject;
    end else begin
      verdict = VerdictSkip;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/anchor_pair_consistency_check.sv
// Top level of the anchor pair consistency check.
// Use: send requests on in_valid/in_stall with req_type and the interval and
// record fields; each request yields one result transfer on out_valid/out_stall
// carrying consistent, table_full and record_count.
// Clear and append need no walk: the result is registered on the edge
// that takes the request. A query rotates the 64-cell record chain once,
// checking the head cell each cycle, and then loads the output register;
// it always walks the whole chain, whatever the record count.
// Only one request is in work at a time; a new one is taken while the prior
// result waits, unless the output register is held by a stalled result.
// When out_stall is high a valid result holds, and a finished query waits on it.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 sets eval_threshold, index 1 sets max_shift; write only when idle.
// Reset empties the table (count to zero), restores eval_threshold to 1.0
// and max_shift to 50, and drops any pending result. Record contents are not
// cleared; only entries below the count are ever examined.
`default_nettype none
module anchor_pair_consistency_check (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [1:0]                    req_type,
  input  wire [apcc_pkg::PosW-1:0]     first_start,
  input  wire [apcc_pkg::PosW-1:0]     first_stop,
  input  wire [apcc_pkg::PosW-1:0]     second_start,
  input  wire [apcc_pkg::PosW-1:0]     second_stop,
  input  wire [apcc_pkg::EvalW-1:0]    record_eval,
  input  wire                          record_valid,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         consistent,
  output logic                         table_full,
  output logic [apcc_pkg::CountW-1:0]  record_count,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_index,
  input  wire [apcc_pkg::EvalW-1:0]    cfg_data
);
  import apcc_pkg::*;

  typedef enum logic {StIdle, StWalk} state_t;

  state_t            state;
  logic [CountW-1:0] entry_count;
  logic [CountW-1:0] step;
  logic              decided, verdict_ok;
  logic [PosW-1:0]   q_s1, q_e1, q_s2, q_e2;
  logic [EvalW-1:0]  eval_threshold;
  logic [ShiftW-1:0] max_shift;

  anchor_rec_t       cells [TableDepth];
  anchor_rec_t       new_rec;
  verdict_t          head_verdict;
  logic              in_xfer, out_free, append_ok, shift_en, walk_done, out_load;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != StIdle) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign append_ok = in_xfer && req_type == ReqAppend && entry_count < CountW'(TableDepth);
  assign shift_en  = (state == StWalk) && !walk_done;
  assign walk_done = step == CountW'(TableDepth);
  assign out_load  = (in_xfer && req_type != ReqQuery) ||
                     (state == StWalk && walk_done && out_free);

  assign new_rec = '{s1: first_start, e1: first_stop, s2: second_start, e2: second_stop,
                     ev: record_eval, valid: record_valid};

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    apcc_cell u_cell (
      .clk         (clk),
      .load_en     (append_ok && entry_count[IdxW-1:0] == IdxW'(i)),
      .shift_en    (shift_en),
      .load_rec    (new_rec),
      .neighbor_rec(cells[(i + 1) % TableDepth]),
      .rec         (cells[i])
    );
  end

  apcc_eval u_eval (
    .rec           (cells[0]),
    .s1            (q_s1),
    .e1            (q_e1),
    .s2            (q_s2),
    .e2            (q_e2),
    .eval_threshold(eval_threshold),
    .max_shift     (max_shift),
    .verdict       (head_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= StIdle;
      entry_count    <= '0;
      out_valid      <= 1'b0;
      step           <= '0;
      decided        <= 1'b0;
      verdict_ok     <= 1'b1;
      eval_threshold <= EvalThresholdReset;
      max_shift      <= MaxShiftReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgEvalThreshold) begin
          eval_threshold <= cfg_data;
        end else begin
          max_shift <= cfg_data[ShiftW-1:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (in_xfer) begin
            q_s1 <= first_start;
            q_e1 <= first_stop;
            q_s2 <= second_start;
            q_e2 <= second_stop;
            if (req_type == ReqQuery) begin
              state      <= StWalk;
              step       <= '0;
              decided    <= 1'b0;
              verdict_ok <= 1'b1;
            end else begin
              consistent   <= 1'b0;
              table_full   <= req_type == ReqAppend && !append_ok;
              if (req_type == ReqClear) begin
                entry_count  <= '0;
                record_count <= '0;
              end else if (append_ok) begin
                entry_count  <= entry_count + 1'b1;
                record_count <= entry_count + 1'b1;
              end else begin
                record_count <= entry_count;
              end
            end
          end
        end
        StWalk: begin
          if (!walk_done) begin
            step <= step + 1'b1;
            // only records below the count take part, first decision wins
            if (!decided && step < entry_count) begin
              if (head_verdict == VerdictAccept) begin
                decided <= 1'b1;
              end else if (head_verdict == VerdictReject) begin
                decided    <= 1'b1;
                verdict_ok <= 1'b0;
              end
            end
          end else if (out_free) begin
            consistent   <= verdict_ok;
            table_full   <= 1'b0;
            record_count <= entry_count;
            state        <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
